[rtl/tls_pkg.sv]
// ----------------------------------------------------------------------------
// tls_pkg: shared types and constants of the traffic light sequencer
// Beat formats, event codes, status characters, lamp bits and reset values.
// ----------------------------------------------------------------------------
package tls_pkg;

  // Input beat: one event
  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] rx_byte;
    logic [1:0] button_index;
  } item_t;

  // Output beat: lamp state plus an optional status character
  typedef struct packed {
    logic       red_on;
    logic       yellow_on;
    logic       green_on;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       last;
  } result_t;

  // Event codes
  localparam logic [1:0] EV_TICK   = 2'd0;
  localparam logic [1:0] EV_BYTE   = 2'd1;
  localparam logic [1:0] EV_BUTTON = 2'd2;

  // Lamp bits
  localparam logic [2:0] LAMP_OFF    = 3'b000;
  localparam logic [2:0] LAMP_RED    = 3'b001;
  localparam logic [2:0] LAMP_YELLOW = 3'b010;
  localparam logic [2:0] LAMP_GREEN  = 3'b100;

  // Light modes
  localparam logic [1:0] LM_RED   = 2'd1;
  localparam logic [1:0] LM_BLINK = 2'd2;
  localparam logic [1:0] LM_CYCLE = 2'd3;

  // Received command characters
  localparam logic [7:0] CMD_TOGGLE = 8'h54; // 'T'
  localparam logic [7:0] CMD_DAY    = 8'h44; // 'D'
  localparam logic [7:0] CMD_NIGHT  = 8'h4E; // 'N'
  localparam logic [7:0] CMD_SET    = 8'h53; // 'S'

  // Digit characters
  localparam logic [7:0] CH_ZERO  = 8'h30; // '0'
  localparam logic [7:0] CH_ONE   = 8'h31; // '1'
  localparam logic [7:0] CH_THREE = 8'h33; // '3'
  localparam logic [7:0] CH_FIVE  = 8'h35; // '5'
  localparam logic [7:0] CH_NINE  = 8'h39; // '9'

  // Status characters
  localparam logic [7:0] TX_NONE   = 8'h00;
  localparam logic [7:0] TX_MANUAL = 8'h4D; // 'M'
  localparam logic [7:0] TX_REMOTE = 8'h41; // 'A'
  localparam logic [7:0] TX_RED    = 8'h52; // 'R'
  localparam logic [7:0] TX_OFF    = 8'h4F; // 'O'
  localparam logic [7:0] TX_YELLOW = 8'h59; // 'Y'
  localparam logic [7:0] TX_GREEN  = 8'h47; // 'G'
  localparam logic [7:0] TX_ERROR  = 8'h45; // 'E'
  localparam logic [7:0] TX_SET_OK = 8'h53; // 'S'

  // Reset durations in seconds
  localparam logic [5:0] RST_RED_SEC    = 6'd5;
  localparam logic [5:0] RST_YELLOW_SEC = 6'd3;
  localparam logic [5:0] RST_GREEN_SEC  = 6'd10;
  localparam logic [5:0] RST_BLINK_SEC  = 6'd1;

  localparam int unsigned NUM_DIGITS = 6;
  localparam int unsigned MAX_SEC    = 63;

  // Two decimal digits to seconds
  function automatic logic [5:0] dec2(input logic [3:0] tens, input logic [3:0] ones);
    logic [7:0] t;
    t = {4'b0, tens} * 8'd10 + {4'b0, ones};
    return t[5:0];
  endfunction

endpackage

[rtl/tls_core.sv]
// ----------------------------------------------------------------------------
// tls_core: controller state and single-pass event update
// Takes one event per fire, updates the event-driven state and forms the result beat.
// ----------------------------------------------------------------------------
module tls_core #(
  parameter int unsigned TICKS_PER_SECOND = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [5:0]       cfg_data_i,
  input  logic             fire_i,
  input  tls_pkg::item_t   item_i,
  output tls_pkg::result_t result_o,
  output logic             has_result_o
);
  import tls_pkg::*;

  localparam int unsigned TW = $clog2(MAX_SEC * TICKS_PER_SECOND + 1);
  localparam int unsigned DW = $clog2(NUM_DIGITS);

  logic [5:0]    blink_sec_q;
  logic [1:0]    light_mode_q, light_mode_d;
  logic          night_q, night_d;
  logic          remote_q, remote_d;
  logic [2:0]    lamps_q, lamps_d;
  logic [TW-1:0] ticks_left_q, ticks_left_d;
  logic          started_q, started_d;
  logic [5:0]    red_sec_q, red_sec_d;
  logic [5:0]    yellow_sec_q, yellow_sec_d;
  logic [5:0]    green_sec_q, green_sec_d;
  logic [DW-1:0] digit_count_q, digit_count_d;
  logic          collecting_q, collecting_d;
  logic          digit_bad_q, digit_bad_d;
  logic [3:0]    digit_store_q [NUM_DIGITS];

  logic          digit_we;
  logic [3:0]    digit_val;
  logic [7:0]    digit_hi;
  logic          digit_err;
  logic          txv;
  logic [7:0]    tx;
  logic [5:0]    phase_sec;
  logic [2:0]    phase_lamps;
  logic [7:0]    phase_ch;
  logic [TW-1:0] phase_prod;

  // Next phase: lamps, report character and duration
  always_comb begin
    phase_lamps = LAMP_RED;
    phase_ch    = TX_RED;
    phase_sec   = red_sec_q;
    priority if (light_mode_q == LM_RED) begin
      phase_lamps = LAMP_RED;
    end else if (light_mode_q == LM_BLINK || night_q) begin
      phase_lamps = lamps_q ^ LAMP_YELLOW;
      phase_ch    = phase_lamps[1] ? TX_YELLOW : TX_OFF;
      phase_sec   = blink_sec_q;
    end else if (lamps_q == LAMP_RED) begin
      phase_lamps = LAMP_YELLOW;
      phase_ch    = TX_YELLOW;
      phase_sec   = yellow_sec_q;
    end else if (lamps_q == LAMP_YELLOW) begin
      phase_lamps = LAMP_GREEN;
      phase_ch    = TX_GREEN;
      phase_sec   = green_sec_q;
    end else begin
      phase_lamps = LAMP_RED;
    end
  end

  assign phase_prod = TW'(phase_sec) * TW'(TICKS_PER_SECOND);

  assign digit_val = 4'(item_i.rx_byte - CH_ZERO);
  assign digit_hi  = digit_count_q[0] ? CH_NINE : CH_FIVE;
  assign digit_err = (item_i.rx_byte < CH_ZERO) || (item_i.rx_byte > digit_hi);

  always_comb begin
    light_mode_d  = light_mode_q;
    night_d       = night_q;
    remote_d      = remote_q;
    lamps_d       = lamps_q;
    ticks_left_d  = ticks_left_q;
    started_d     = started_q;
    red_sec_d     = red_sec_q;
    yellow_sec_d  = yellow_sec_q;
    green_sec_d   = green_sec_q;
    digit_count_d = digit_count_q;
    collecting_d  = collecting_q;
    digit_bad_d   = digit_bad_q;
    digit_we      = 1'b0;
    txv           = 1'b0;
    tx            = TX_NONE;

    unique case (item_i.mode)
      EV_TICK: begin
        if (!collecting_q) begin
          if (started_q && ticks_left_q > TW'(1)) begin
            ticks_left_d = ticks_left_q - TW'(1);
          end else begin
            lamps_d      = phase_lamps;
            ticks_left_d = (phase_prod == '0) ? TW'(1) : phase_prod;
            started_d    = 1'b1;
            txv          = 1'b1;
            tx           = phase_ch;
          end
        end
      end
      EV_BYTE: begin
        if (collecting_q) begin
          if (item_i.rx_byte == CMD_SET) begin
            digit_count_d = '0;
            digit_bad_d   = 1'b0;
          end else begin
            digit_we      = 1'b1;
            digit_bad_d   = digit_bad_q | digit_err;
            digit_count_d = digit_count_q + DW'(1);
            // sixth digit closes the load
            if (digit_count_q == DW'(NUM_DIGITS - 1)) begin
              txv = 1'b1;
              if (digit_bad_q || digit_err) begin
                tx = TX_ERROR;
              end else begin
                red_sec_d    = dec2(digit_store_q[0], digit_store_q[1]);
                yellow_sec_d = dec2(digit_store_q[2], digit_store_q[3]);
                green_sec_d  = dec2(digit_store_q[4], digit_val);
                tx           = TX_SET_OK;
              end
              collecting_d  = 1'b0;
              digit_count_d = '0;
              digit_bad_d   = 1'b0;
              if (light_mode_q == LM_CYCLE) begin
                lamps_d   = LAMP_OFF;
                started_d = 1'b0;
              end
            end
          end
        end else if (item_i.rx_byte == CMD_TOGGLE) begin
          remote_d = ~remote_q;
          txv      = 1'b1;
          tx       = remote_d ? TX_REMOTE : TX_MANUAL;
        end else if (item_i.rx_byte == CMD_DAY || item_i.rx_byte == CMD_NIGHT) begin
          night_d = (item_i.rx_byte == CMD_NIGHT);
          if (light_mode_q == LM_CYCLE) begin
            lamps_d   = LAMP_OFF;
            started_d = 1'b0;
          end
        end else if (item_i.rx_byte == CMD_SET) begin
          collecting_d  = 1'b1;
          digit_count_d = '0;
          digit_bad_d   = 1'b0;
        end else if (remote_q && item_i.rx_byte >= CH_ONE && item_i.rx_byte <= CH_THREE) begin
          light_mode_d = item_i.rx_byte[1:0];
          lamps_d      = LAMP_OFF;
          started_d    = 1'b0;
          txv          = 1'b1;
          tx           = item_i.rx_byte;
        end
      end
      EV_BUTTON: begin
        if (!collecting_q && !remote_q && item_i.button_index != 2'd3) begin
          light_mode_d = item_i.button_index + 2'd1;
          lamps_d      = LAMP_OFF;
          started_d    = 1'b0;
          txv          = 1'b1;
          tx           = CH_ZERO + {6'b0, light_mode_d};
        end
      end
      default: begin
      end
    endcase
  end

  assign has_result_o       = txv || (lamps_d != lamps_q);
  assign result_o.red_on    = lamps_d[0];
  assign result_o.yellow_on = lamps_d[1];
  assign result_o.green_on  = lamps_d[2];
  assign result_o.tx_valid  = txv;
  assign result_o.tx_byte   = tx;
  assign result_o.last      = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blink_sec_q   <= RST_BLINK_SEC;
      light_mode_q  <= LM_CYCLE;
      night_q       <= 1'b0;
      remote_q      <= 1'b0;
      lamps_q       <= LAMP_OFF;
      ticks_left_q  <= '0;
      started_q     <= 1'b0;
      red_sec_q     <= RST_RED_SEC;
      yellow_sec_q  <= RST_YELLOW_SEC;
      green_sec_q   <= RST_GREEN_SEC;
      digit_count_q <= '0;
      collecting_q  <= 1'b0;
      digit_bad_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        blink_sec_q <= cfg_data_i;
      end
      if (fire_i) begin
        light_mode_q  <= light_mode_d;
        night_q       <= night_d;
        remote_q      <= remote_d;
        lamps_q       <= lamps_d;
        ticks_left_q  <= ticks_left_d;
        started_q     <= started_d;
        red_sec_q     <= red_sec_d;
        yellow_sec_q  <= yellow_sec_d;
        green_sec_q   <= green_sec_d;
        digit_count_q <= digit_count_d;
        collecting_q  <= collecting_d;
        digit_bad_q   <= digit_bad_d;
      end
    end
  end

  // digit store, no reset
  always_ff @(posedge clk_i) begin
    if (fire_i && digit_we) begin
      digit_store_q[digit_count_q] <= digit_val;
    end
  end

  a_one_lamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(lamps_q) <= 1)
    else $error("more than one lamp on");

  a_ticks_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    started_q |-> ticks_left_q != '0)
    else $error("phase running with zero ticks left");

  a_digit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    digit_count_q < DW'(NUM_DIGITS) && (collecting_q || digit_count_q == '0))
    else $error("digit count out of range");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    collecting_q && fire_i && item_i.mode != EV_BYTE |=> $stable(lamps_q))
    else $error("lamps changed while loading durations");

endmodule

[rtl/traffic_light_sequencer.sv]
// ----------------------------------------------------------------------------
// traffic_light_sequencer: top level
// Event beats (tick, received byte, button) in; lamp and status beats out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i/in_stall_o carries one event per beat. Output
//   channel out_valid_o/out_stall_i carries at most one result beat per
//   event; events that change no lamp and send no character give no beat.
//   The config channel cfg_valid_i/cfg_ready_o writes blink_seconds; it is
//   always ready and should be written only while the block is idle.
//   Path: an event is registered in the event stage; when it fires it is
//   evaluated in one pass against the controller state and its result is
//   registered in the output register. Throughput is one event per cycle
//   while no stalled result holds the event stage; the state update in
//   tls_core is a single pass.
//   Reset: light mode 3 (day cycle), manual control, lamps off, no phase
//   running; the first tick starts the red phase.
//   Stall: while out_stall_i holds a result, the event stage holds too and
//   in_stall_o rises once that stage is occupied.
// ----------------------------------------------------------------------------
module traffic_light_sequencer #(
  parameter int unsigned TICKS_PER_SECOND = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  tls_pkg::item_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output tls_pkg::result_t out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [5:0]       cfg_data_i
);
  import tls_pkg::*;

  logic    s1_valid_q;
  item_t   s1_item_q;
  logic    s1_adv;
  logic    fire;
  logic    in_accept;
  logic    out_valid_q;
  result_t out_data_q;
  result_t core_result;
  logic    core_has_result;

  assign cfg_ready_o = 1'b1;

  // the event stage moves when the output register is free or being drained
  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && s1_adv;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  tls_core #(
    .TICKS_PER_SECOND(TICKS_PER_SECOND)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .fire_i       (fire),
    .item_i       (s1_item_q),
    .result_o     (core_result),
    .has_result_o (core_has_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_adv) begin
        out_valid_q <= fire && core_has_result;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q <= in_data_i;
    end
    if (fire && core_has_result) begin
      out_data_q <= core_result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(out_data_q))
    else $error("stalled result beat lost or changed");

  a_tx_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_data_q.tx_valid |-> out_data_q.tx_byte == TX_NONE)
    else $error("tx byte set without tx valid");

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> s1_valid_q && $stable(s1_item_q))
    else $error("event stage changed while stalled");

endmodule

[sim/traffic_light_sequencer_tb.sv]
// ----------------------------------------------------------------------------
// traffic_light_sequencer_tb: self-checking bench for the traffic light block
// Drives ticks, host bytes and button presses with random gaps and output
// stalls. A scoreboard class tracks lamp, mode and duration state, and checks
// every output beat in order. blink_seconds is rewritten between idle phases.
// ----------------------------------------------------------------------------
module traffic_light_sequencer_tb;
  import tls_pkg::*;

  localparam int unsigned TPS = 10;
  localparam logic [1:0] EV_NONE = 2'd3;  // unused event code, must be ignored
  localparam int PHASE_EVENTS = 250;

  class lamp_scoreboard;
    result_t    beats_q[$];
    int         errors;
    logic [5:0] blink_sec;
    logic [1:0] mode_sel;
    logic       is_night, is_remote, phase_live, collecting, digit_err;
    logic [2:0] lamp_q;
    int         phase_left, digit_n;
    logic [5:0] dur_red, dur_yellow, dur_green;
    logic [3:0] digits[NUM_DIGITS];

    function new();
      errors = 0;
      blink_sec = RST_BLINK_SEC;
      mode_sel = LM_CYCLE;
      is_night = 1'b0;
      is_remote = 1'b0;
      phase_live = 1'b0;
      collecting = 1'b0;
      digit_err = 1'b0;
      lamp_q = LAMP_OFF;
      phase_left = 0;
      digit_n = 0;
      dur_red = RST_RED_SEC;
      dur_yellow = RST_YELLOW_SEC;
      dur_green = RST_GREEN_SEC;
      foreach (digits[k]) digits[k] = 4'd0;
    endfunction

    function void drop_phase();
      lamp_q = LAMP_OFF;
      phase_live = 1'b0;
    endfunction

    function logic [7:0] pick_mode(logic [1:0] m);
      mode_sel = m;
      drop_phase();
      return CH_ZERO + m;
    endfunction

    function logic [7:0] next_phase();
      logic [7:0] ch;
      logic [5:0] sec;
      if (mode_sel == LM_RED) begin
        lamp_q = LAMP_RED; ch = TX_RED; sec = dur_red;
      end else if (mode_sel == LM_BLINK || is_night) begin
        lamp_q = lamp_q ^ LAMP_YELLOW;
        ch = ((lamp_q & LAMP_YELLOW) != LAMP_OFF) ? TX_YELLOW : TX_OFF;
        sec = blink_sec;
      end else if (lamp_q == LAMP_RED) begin
        lamp_q = LAMP_YELLOW; ch = TX_YELLOW; sec = dur_yellow;
      end else if (lamp_q == LAMP_YELLOW) begin
        lamp_q = LAMP_GREEN; ch = TX_GREEN; sec = dur_green;
      end else begin
        lamp_q = LAMP_RED; ch = TX_RED; sec = dur_red;
      end
      phase_left = int'(sec) * TPS;
      if (phase_left == 0) phase_left = 1;  // zero seconds still lasts a tick
      phase_live = 1'b1;
      return ch;
    endfunction

    // Applies one accepted event; returns 1 unless the block ignores it.
    function bit take_event(item_t ev);
      logic [2:0] prior;
      logic       sends;
      logic [7:0] ch, b, off, top;
      bit         acted;
      result_t    r;
      prior = lamp_q;
      sends = 1'b0;
      ch = TX_NONE;
      acted = 1'b0;
      b = ev.rx_byte;
      off = b - CH_ZERO;
      case (ev.mode)
        EV_TICK: begin
          if (!collecting) begin
            acted = 1'b1;
            if (phase_live && phase_left > 1) begin
              phase_left--;
            end else begin
              ch = next_phase();
              sends = 1'b1;
            end
          end
        end
        EV_BYTE: begin
          if (collecting) begin
            acted = 1'b1;
            if (b == CMD_SET) begin
              digit_n = 0;
              digit_err = 1'b0;
            end else begin
              top = (digit_n % 2 == 1) ? CH_NINE : CH_FIVE;
              if (b < CH_ZERO || b > top) digit_err = 1'b1;
              digits[digit_n] = off[3:0];
              digit_n++;
              if (digit_n >= NUM_DIGITS) begin
                if (digit_err) begin
                  ch = TX_ERROR;
                end else begin
                  dur_red    = 6'(int'(digits[0]) * 10 + int'(digits[1]));
                  dur_yellow = 6'(int'(digits[2]) * 10 + int'(digits[3]));
                  dur_green  = 6'(int'(digits[4]) * 10 + int'(digits[5]));
                  ch = TX_SET_OK;
                end
                sends = 1'b1;
                collecting = 1'b0;
                digit_n = 0;
                digit_err = 1'b0;
                if (mode_sel == LM_CYCLE) drop_phase();
              end
            end
          end else if (b == CMD_TOGGLE) begin
            acted = 1'b1;
            is_remote = !is_remote;
            ch = is_remote ? TX_REMOTE : TX_MANUAL;
            sends = 1'b1;
          end else if (b == CMD_DAY || b == CMD_NIGHT) begin
            acted = 1'b1;
            is_night = (b == CMD_NIGHT);
            if (mode_sel == LM_CYCLE) drop_phase();
          end else if (b == CMD_SET) begin
            acted = 1'b1;
            collecting = 1'b1;
            digit_n = 0;
            digit_err = 1'b0;
          end else if (is_remote && b >= CH_ONE && b <= CH_THREE) begin
            acted = 1'b1;
            ch = pick_mode(off[1:0]);
            sends = 1'b1;
          end
        end
        EV_BUTTON: begin
          if (!collecting && !is_remote && ev.button_index <= 2'd2) begin
            acted = 1'b1;
            ch = pick_mode(ev.button_index + 2'd1);
            sends = 1'b1;
          end
        end
        default: ;
      endcase
      if (sends || lamp_q != prior) begin
        r.red_on    = lamp_q[0];
        r.yellow_on = lamp_q[1];
        r.green_on  = lamp_q[2];
        r.tx_valid  = sends;
        r.tx_byte   = sends ? ch : TX_NONE;
        r.last      = 1'b1;
        beats_q.push_back(r);
      end
      return acted;
    endfunction

    function void check_beat(result_t got);
      result_t want;
      if (beats_q.size() == 0) begin
        if (errors < 10)
          $display("unexpected beat: r%b y%b g%b txv%b tx=%h last%b", got.red_on,
                   got.yellow_on, got.green_on, got.tx_valid, got.tx_byte, got.last);
        errors++;
        return;
      end
      want = beats_q.pop_front();
      if (got.red_on !== want.red_on || got.yellow_on !== want.yellow_on ||
          got.green_on !== want.green_on || got.tx_valid !== want.tx_valid ||
          got.tx_byte !== want.tx_byte || got.last !== want.last) begin
        if (errors < 10)
          $display("mismatch: exp r%b y%b g%b v%b tx=%h l%b got r%b y%b g%b v%b tx=%h l%b",
                   want.red_on, want.yellow_on, want.green_on, want.tx_valid,
                   want.tx_byte, want.last, got.red_on, got.yellow_on,
                   got.green_on, got.tx_valid, got.tx_byte, got.last);
        errors++;
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  item_t      in_data_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  result_t    out_data_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [5:0] cfg_data_i = '0;

  lamp_scoreboard sb;
  bit calm = 1'b0;
  int acted_n = 0;

  traffic_light_sequencer #(.TICKS_PER_SECOND(TPS)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("== FAIL ==");
    $finish;
  end

  // Result side: check accepted beats, then pick the next stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_beat(out_data_o);
      out_stall_i <= !calm && ($urandom_range(99) < 18);
    end
  end

  // Called at a rising edge; returns at the edge that accepted the beat.
  task automatic send_item(item_t it);
    while (!calm && $urandom_range(99) < 18) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    if (sb.take_event(it)) acted_n++;
  endtask

  task automatic send_tick();
    item_t it;
    it.mode = EV_TICK;
    it.rx_byte = 8'($urandom);
    it.button_index = 2'($urandom);
    send_item(it);
  endtask

  task automatic send_byte(logic [7:0] b);
    item_t it;
    it.mode = EV_BYTE;
    it.rx_byte = b;
    it.button_index = 2'($urandom);
    send_item(it);
  endtask

  task automatic send_button(logic [1:0] n);
    item_t it;
    it.mode = EV_BUTTON;
    it.rx_byte = 8'($urandom);
    it.button_index = n;
    send_item(it);
  endtask

  // Stop sending and wait until every expected beat has arrived
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.beats_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_blink(logic [5:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.blink_sec = v;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [7:0] pick_digit(int pos);
    int r;
    r = $urandom_range(99);
    if (r < 5) return 8'($urandom);  // broken digit
    if (r < 60) return CH_ZERO + 8'((pos % 2 == 1) ? $urandom_range(2) : 0);
    return CH_ZERO + 8'($urandom_range((pos % 2 == 1) ? 9 : 5));
  endfunction

  // 'S' plus six digits, with the odd ignored event or restart mixed in
  task automatic send_duration_load();
    int k;
    k = 0;
    send_byte(CMD_SET);
    while (k < NUM_DIGITS) begin
      if ($urandom_range(99) < 5) begin
        if ($urandom_range(1) == 1) send_tick();
        else send_button(2'($urandom));
      end
      if (k > 0 && $urandom_range(99) < 3) begin
        send_byte(CMD_SET);
        k = 0;
      end
      send_byte(pick_digit(k));
      k++;
    end
  endtask

  task automatic random_events(int goal);
    int r;
    logic [11:0] raw;
    logic [7:0] cmd;
    goal += acted_n;
    while (acted_n < goal) begin
      r = $urandom_range(99);
      if (r < 55) begin
        send_tick();
      end else if (r < 65) begin
        send_duration_load();
      end else if (r < 75) begin
        case ($urandom_range(5))
          0: cmd = CMD_TOGGLE;
          1: cmd = CMD_DAY;
          2: cmd = CMD_NIGHT;
          default: cmd = CH_ZERO + 8'($urandom_range(1, 3));
        endcase
        send_byte(cmd);
      end else if (r < 85) begin
        send_button(2'($urandom));
      end else if (r < 93) begin
        send_byte(8'($urandom));
      end else begin
        raw = 12'($urandom);
        send_item(raw);
      end
    end
  endtask

  initial begin
    item_t odd;
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: first tick, digit load with restart, day/night, remote, buttons
    send_tick();
    send_byte(CMD_SET);
    send_byte(CH_NINE);
    send_tick();
    send_button(2'd0);
    send_byte(CMD_SET);
    send_byte(CH_ZERO);
    send_byte(CH_NINE);
    send_byte(CH_ZERO);
    send_byte(CH_ZERO);
    send_byte(CH_FIVE);
    send_byte(CH_NINE);
    send_tick();
    send_byte(CMD_NIGHT);
    send_tick();
    send_byte(CMD_DAY);
    send_byte(CMD_TOGGLE);
    send_byte(CH_ZERO + 8'd2);
    send_button(2'd1);
    send_byte(CMD_TOGGLE);
    send_byte(CH_ONE);
    send_button(2'd0);
    send_button(2'd3);
    odd.mode = EV_NONE;
    odd.rx_byte = 8'hFF;
    odd.button_index = 2'd3;
    send_item(odd);
    send_button(2'd2);
    settle();

    write_blink(6'd59);
    random_events(PHASE_EVENTS);
    settle();
    write_blink(6'($urandom_range(2, 58)));
    random_events(PHASE_EVENTS);
    settle();
    write_blink(6'd1);
    calm = 1'b1;
    random_events(PHASE_EVENTS);
    calm = 1'b0;
    settle();
    write_blink(6'($urandom_range(1, 5)));
    random_events(PHASE_EVENTS);
    settle();

    if (sb.errors == 0 && sb.beats_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[traffic_light_sequencer.f]
rtl/tls_pkg.sv
rtl/tls_core.sv
rtl/traffic_light_sequencer.sv
sim/traffic_light_sequencer_tb.sv
